// ----- rtl/bcpo_pkg.sv -----
// Package: widths, defaults and register indexes for the box push-out block.
`timescale 1ns / 1ps
`default_nettype none
package bcpo_pkg;
    // coordinates are Q15.16; every step scales alike, so this never enters the math
    localparam int FRAC_BITS = 16;
    localparam int CRD_W = 32;
    localparam int HLF_W = 31;
    localparam logic [1:0] REG_HX = 2'd0;
    localparam logic [1:0] REG_HY = 2'd1;
    localparam logic [1:0] REG_HZ = 2'd2;
    localparam logic [30:0] HALF_RESET = 31'd65536;

    typedef struct packed {
        logic                   kind;
        logic signed [31:0]     self_x;
        logic signed [31:0]     self_y;
        logic signed [31:0]     self_z;
        logic signed [31:0]     other_x;
        logic signed [31:0]     other_y;
        logic signed [31:0]     other_z;
        logic [30:0]            other_half_x;
        logic [30:0]            other_half_y;
        logic [30:0]            other_half_z;
        logic [30:0]            other_radius;
    } t_item;

    // front result: the pieces the back part needs
    typedef struct packed {
        logic               kind;
        logic               hit;
        logic [1:0]         axis;
        logic [33:0]        half;
        logic               neg_box;
        logic signed [33:0] self_x;
        logic signed [33:0] self_y;
        logic signed [33:0] self_z;
        logic [33:0]        m_x;
        logic [33:0]        m_y;
        logic [33:0]        m_z;
        logic               neg_x;
        logic               neg_y;
        logic               neg_z;
        logic [30:0]        radius;
    } t_cls;

    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_z;
        logic               moved;
    } t_res;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) return 32'sh7fffffff;
        if (v < -36'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

// ----- rtl/box_collision_push_out.sv -----
// Top level: AABB push-out resolver with stream ports and register port.
// Usage: s_axis words carry one collision event; m_axis words carry the
// corrected centre and the moved flag, one result per event, in order.
// Registers half_extent_x/y/z (index 0..2) are written on the cfg channel
// by the user only while idle, which the block does not enforce; reset
// sets each to 1.0. Throughput: one word per cycle while not stalled.
// An event passes one front stage, one queue slot and 38 back stages, set
// by the two-bit-per-stage square root and long division pipelines.
// The front classifies in one stage and feeds a 4-deep queue; the back
// pipeline advances while its output register is free or taken.
// When m_axis_tready is low the back stalls, the queue fills, then
// s_axis_tready drops. Synchronous active-low reset empties everything.
`timescale 1ns / 1ps
`default_nettype none
module box_collision_push_out
    import bcpo_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: self_x, self_y, self_z, other_x, other_y, other_z,
    //        other_half_x, other_half_y, other_half_z, other_radius, pad
    input  wire  [319:0] s_axis_tdata,
    // tuser: kind
    input  wire          s_axis_tuser,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // tdata: new_x, new_y, new_z
    output logic [95:0]  m_axis_tdata,
    // tuser: moved
    output logic         m_axis_tuser,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [1:0]   i_cfg_index,
    input  wire  [30:0]  i_cfg_data
);
    logic [30:0] r_h [3];
    t_item it;
    t_cls  f_cls, q_cls;
    t_res  b_res;
    logic  f_valid, q_empty, q_full, b_valid, b_en, f_en, q_rd, q_wr;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h[0] <= HALF_RESET; r_h[1] <= HALF_RESET; r_h[2] <= HALF_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_HX: r_h[0] <= i_cfg_data;
                REG_HY: r_h[1] <= i_cfg_data;
                REG_HZ: r_h[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign it.kind = s_axis_tuser;
    assign it.self_x  = s_axis_tdata[31:0];
    assign it.self_y  = s_axis_tdata[63:32];
    assign it.self_z  = s_axis_tdata[95:64];
    assign it.other_x = s_axis_tdata[127:96];
    assign it.other_y = s_axis_tdata[159:128];
    assign it.other_z = s_axis_tdata[191:160];
    assign it.other_half_x = s_axis_tdata[222:192];
    assign it.other_half_y = s_axis_tdata[253:223];
    assign it.other_half_z = s_axis_tdata[284:254];
    assign it.other_radius = s_axis_tdata[315:285];

    // front may advance when its register is empty or drains into the queue
    assign q_wr = f_valid && !q_full;
    assign f_en = !f_valid || !q_full;
    assign s_axis_tready = f_en;

    bcpo_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(f_en),
        .i_valid(s_axis_tvalid), .i_item(it),
        .i_hx(r_h[0]), .i_hy(r_h[1]), .i_hz(r_h[2]),
        .o_valid(f_valid), .o_cls(f_cls)
    );

    bcpo_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr(q_wr), .i_data(f_cls),
        .i_rd(q_rd), .o_empty(q_empty), .o_full(q_full), .o_data(q_cls)
    );

    assign b_en = !b_valid || m_axis_tready;
    assign q_rd = b_en && !q_empty;

    bcpo_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(b_en),
        .i_valid(q_rd), .i_cls(q_cls),
        .o_valid(b_valid), .o_res(b_res)
    );

    assign m_axis_tvalid = b_valid;
    assign m_axis_tdata  = {b_res.new_z, b_res.new_y, b_res.new_x};
    assign m_axis_tuser  = b_res.moved;
endmodule
`default_nettype wire

// ----- rtl/bcpo_front.sv -----
// Front part: overlap, clamp and axis choice, one registered stage.
`timescale 1ns / 1ps
`default_nettype none
module bcpo_front
    import bcpo_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_en,
    input  wire         i_valid,
    input  t_item       i_item,
    input  wire  [30:0] i_hx,
    input  wire  [30:0] i_hy,
    input  wire  [30:0] i_hz,
    output logic        o_valid,
    output t_cls        o_cls
);
    logic signed [33:0] s [3];
    logic signed [33:0] o [3];
    logic signed [33:0] h [3];
    logic signed [33:0] oh [3];
    logic signed [33:0] ov [3];
    logic [33:0]        m [3];
    logic               ng [3];
    logic               hit, near;
    logic [1:0]         ax;
    t_cls               n_cls;
    t_cls               r_cls;
    logic               r_valid;

    always_comb begin
        logic signed [33:0] hi, lo, c, d;
        s[0] = 34'(i_item.self_x);  s[1] = 34'(i_item.self_y);  s[2] = 34'(i_item.self_z);
        o[0] = 34'(i_item.other_x); o[1] = 34'(i_item.other_y); o[2] = 34'(i_item.other_z);
        h[0] = {3'b0, i_hx}; h[1] = {3'b0, i_hy}; h[2] = {3'b0, i_hz};
        oh[0] = {3'b0, i_item.other_half_x};
        oh[1] = {3'b0, i_item.other_half_y};
        oh[2] = {3'b0, i_item.other_half_z};
        hit = 1'b1;
        near = 1'b1;
        for (int i = 0; i < 3; i++) begin
            hi = (o[i] + oh[i] < s[i] + h[i]) ? o[i] + oh[i] : s[i] + h[i];
            lo = (o[i] - oh[i] > s[i] - h[i]) ? o[i] - oh[i] : s[i] - h[i];
            ov[i] = hi - lo;
            if (ov[i] <= 0) hit = 1'b0;
            c = o[i];
            if (c > s[i] + h[i]) c = s[i] + h[i];
            if (c < s[i] - h[i]) c = s[i] - h[i];
            d = c - o[i];
            ng[i] = d[33];
            m[i] = d[33] ? 34'(-d) : d;
            if (m[i] >= {3'b0, i_item.other_radius}) near = 1'b0;
        end
        ax = 2'd0;
        if (ov[1] < ov[0]) ax = 2'd1;
        if (ov[2] < ov[ax]) ax = 2'd2;
        n_cls.kind    = i_item.kind;
        n_cls.hit     = i_item.kind ? near : hit;
        n_cls.axis    = ax;
        n_cls.half    = 34'(ov[ax] >>> 1);
        n_cls.neg_box = s[ax] < o[ax];
        n_cls.self_x  = s[0];
        n_cls.self_y  = s[1];
        n_cls.self_z  = s[2];
        n_cls.m_x = m[0]; n_cls.m_y = m[1]; n_cls.m_z = m[2];
        n_cls.neg_x = ng[0]; n_cls.neg_y = ng[1]; n_cls.neg_z = ng[2];
        n_cls.radius = i_item.other_radius;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) r_cls <= n_cls;
    end
    assign o_valid = r_valid;
    assign o_cls   = r_cls;
endmodule
`default_nettype wire

// ----- rtl/bcpo_fifo.sv -----
// Short queue between front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module bcpo_fifo
    import bcpo_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_wr,
    input  t_cls  i_data,
    input  wire   i_rd,
    output logic  o_empty,
    output logic  o_full,
    output t_cls  o_data
);
    t_cls       r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_wr) r_wp <= r_wp + 2'd1;
            if (i_rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, i_wr} - {2'b0, i_rd};
        end
        if (i_wr) r_mem[r_wp] <= i_data;
    end
    assign o_data  = r_mem[r_rp];
    assign o_empty = r_cnt == 3'd0;
    assign o_full  = r_cnt == 3'd4;
endmodule
`default_nettype wire

// ----- rtl/bcpo_back.sv -----
// Back: sphere distance, sqrt, scaled or box push, saturation; a pipeline.
`timescale 1ns / 1ps
`default_nettype none
module bcpo_back
    import bcpo_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_en,
    input  wire   i_valid,
    input  t_cls  i_cls,
    output logic  o_valid,
    output t_res  o_res
);
    localparam int SQ = 32;   // sqrt steps, two per stage
    localparam int NS = SQ / 2;
    localparam int NDV = 34;  // quotient bits, two per stage
    localparam int ND = NDV / 2;
    localparam int L = 2 + NS + 1 + ND + 1;

    typedef struct packed {
        logic               v;
        t_cls               c;
        logic [63:0]        r2;
        logic [63:0]        sum;
        logic [63:0]        rem;
        logic [31:0]        root;
        logic [31:0]        dlen;
        logic signed [32:0] pen;
        logic               ok;
        logic [65:0]        num_x, num_y, num_z;
        logic [33:0]        q_x, q_y, q_z;
        logic [65:0]        rx, ry, rz;
    } t_st;

    t_st r_p [L+1];
    t_st n_p [L+1];

    function automatic void div_step(input logic [31:0] dv, inout logic [65:0] num,
                                     inout logic [65:0] r, inout logic [33:0] q);
        logic [66:0] t;
        t = {r, num[65]};
        num = {num[64:0], 1'b0};
        if (t >= {35'b0, dv}) begin
            r = 66'(t - {35'b0, dv}); q = {q[32:0], 1'b1};
        end else begin
            r = t[65:0]; q = {q[32:0], 1'b0};
        end
    endfunction

    always_comb begin
        t_st t;
        logic [63:0] bit_v, tr;
        logic signed [35:0] rr [3];
        logic [33:0] mm [3];
        for (int k = 0; k <= L; k++) n_p[k] = r_p[k];
        n_p[0] = '0;
        n_p[0].v = i_valid;
        n_p[0].c = i_cls;
        // squares and r^2, stage 1; a near sphere keeps every |d| below 2^31
        t = r_p[0];
        t.num_x = 66'(62'(t.c.m_x[30:0]) * 62'(t.c.m_x[30:0]));
        t.num_y = 66'(62'(t.c.m_y[30:0]) * 62'(t.c.m_y[30:0]));
        t.num_z = 66'(62'(t.c.m_z[30:0]) * 62'(t.c.m_z[30:0]));
        t.r2 = 64'(62'(t.c.radius) * 62'(t.c.radius));
        n_p[1] = t;
        // sum and compare, stage 2
        t = r_p[1];
        t.sum = 64'(t.num_x) + 64'(t.num_y) + 64'(t.num_z);
        t.ok = t.c.hit && t.sum != '0 && t.sum < t.r2;
        t.rem = t.sum; t.root = '0;
        n_p[2] = t;
        // square root, restoring, two bits a stage
        for (int k = 0; k < NS; k++) begin
            t = r_p[2 + k];
            for (int j = 0; j < 2; j++) begin
                bit_v = 64'd1 << (62 - 2 * (2 * k + j));
                tr = (64'(t.root) << (32 - (2 * k + j))) + bit_v;
                if (t.rem >= tr) begin
                    t.rem = t.rem - tr;
                    t.root = t.root | 32'(64'd1 << (31 - (2 * k + j)));
                end
            end
            n_p[3 + k] = t;
        end
        // rounding and penetration
        t = r_p[2 + NS];
        t.dlen = t.root + ((t.rem > 64'(t.root)) ? 32'd1 : 32'd0);
        t.pen = $signed({2'b0, t.c.radius}) - $signed({1'b0, t.dlen});
        t.ok = t.ok && t.pen > 33'sd0;
        n_p[3 + NS] = t;
        // numerators m*pen + dist/2; top bits preload the remainder
        t = r_p[3 + NS];
        t.num_x = 66'(62'(t.c.m_x[30:0]) * 62'(t.pen[30:0])) + 66'(t.dlen >> 1);
        t.num_y = 66'(62'(t.c.m_y[30:0]) * 62'(t.pen[30:0])) + 66'(t.dlen >> 1);
        t.num_z = 66'(62'(t.c.m_z[30:0]) * 62'(t.pen[30:0])) + 66'(t.dlen >> 1);
        t.rx = t.num_x >> 34; t.ry = t.num_y >> 34; t.rz = t.num_z >> 34;
        t.q_x = '0; t.q_y = '0; t.q_z = '0;
        t.num_x = t.num_x << 32;
        t.num_y = t.num_y << 32;
        t.num_z = t.num_z << 32;
        n_p[4 + NS] = t;
        // long division, two quotient bits a stage
        for (int k = 0; k < ND - 1; k++) begin
            t = r_p[4 + NS + k];
            for (int j = 0; j < 2; j++) begin
                div_step(t.dlen, t.num_x, t.rx, t.q_x);
                div_step(t.dlen, t.num_y, t.ry, t.q_y);
                div_step(t.dlen, t.num_z, t.rz, t.q_z);
            end
            n_p[5 + NS + k] = t;
        end
        // final apply
        t = r_p[L - 1];
        for (int j = 0; j < 2; j++) begin
            div_step(t.dlen, t.num_x, t.rx, t.q_x);
            div_step(t.dlen, t.num_y, t.ry, t.q_y);
            div_step(t.dlen, t.num_z, t.rz, t.q_z);
        end
        mm[0] = t.q_x; mm[1] = t.q_y; mm[2] = t.q_z;
        rr[0] = 36'(t.c.self_x); rr[1] = 36'(t.c.self_y); rr[2] = 36'(t.c.self_z);
        if (t.c.kind) begin
            if (t.ok) begin
                rr[0] = t.c.neg_x ? rr[0] - 36'(mm[0]) : rr[0] + 36'(mm[0]);
                rr[1] = t.c.neg_y ? rr[1] - 36'(mm[1]) : rr[1] + 36'(mm[1]);
                rr[2] = t.c.neg_z ? rr[2] - 36'(mm[2]) : rr[2] + 36'(mm[2]);
            end
        end else if (t.c.hit) begin
            rr[t.c.axis] = t.c.neg_box ? rr[t.c.axis] - 36'(t.c.half)
                                       : rr[t.c.axis] + 36'(t.c.half);
        end
        t.ok = t.c.kind ? t.ok : t.c.hit;
        t.num_x = 66'(sat32(rr[0]));
        t.num_y = 66'(sat32(rr[1]));
        t.num_z = 66'(sat32(rr[2]));
        n_p[L] = t;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= L; k++) r_p[k].v <= 1'b0;
        end else if (i_en) begin
            for (int k = 0; k <= L; k++) r_p[k] <= n_p[k];
        end
    end

    assign o_valid     = r_p[L].v;
    assign o_res.new_x = r_p[L].num_x[31:0];
    assign o_res.new_y = r_p[L].num_y[31:0];
    assign o_res.new_z = r_p[L].num_z[31:0];
    assign o_res.moved = r_p[L].ok;
endmodule
`default_nettype wire

// ----- bench/tb_box_collision_push_out.sv -----
// Testbench: box push-out resolver, directed and random events checked against a predictor.
`timescale 1ns / 1ps
module tb_box_collision_push_out;
    import bcpo_pkg::*;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [319:0]  s_axis_tdata = '0;
    logic          s_axis_tuser = 1'b0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [95:0]   m_axis_tdata;
    logic          m_axis_tuser;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index = '0;
    logic [30:0]   i_cfg_data = '0;

    box_collision_push_out dut (.*);

    initial forever #10 i_clk = ~i_clk;

    initial begin
        #(20.0 * 3000000);
        $display("[box_collision_push_out] ERROR");
        $finish;
    end

    longint unsigned hext [3];
    t_res    pos_q [$];
    int      n_err = 0;
    int      n_sent = 0;
    int      n_moved = 0;
    int      n_recv = 0;
    bit      no_idle = 1'b0;

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned acc, b;
        acc = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= acc + b) begin
                v = v - (acc + b);
                acc = (acc >> 1) + b;
            end else begin
                acc = acc >> 1;
            end
            b = b >> 2;
        end
        return acc;
    endfunction

    function automatic logic signed [31:0] clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic t_res push_out(t_item it);
        longint s [3], o [3], hb [3], ohf [3], pos [3], ov [3], d [3];
        longint hi, lo, c, rad, pen, mv, hv;
        longint unsigned m, sum, r2, dlen;
        bit hit, near, mv_f;
        int ax;
        t_res q;
        s[0] = it.self_x;  s[1] = it.self_y;  s[2] = it.self_z;
        o[0] = it.other_x; o[1] = it.other_y; o[2] = it.other_z;
        ohf[0] = it.other_half_x; ohf[1] = it.other_half_y; ohf[2] = it.other_half_z;
        mv_f = 1'b0;
        for (int i = 0; i < 3; i++) begin
            hb[i] = longint'(hext[i]);
            pos[i] = s[i];
        end
        if (!it.kind) begin
            hit = 1'b1;
            for (int i = 0; i < 3; i++) begin
                hi = s[i] + hb[i];
                lo = s[i] - hb[i];
                if (o[i] + ohf[i] < hi) hi = o[i] + ohf[i];
                if (o[i] - ohf[i] > lo) lo = o[i] - ohf[i];
                ov[i] = hi - lo;
                if (ov[i] <= 0) hit = 1'b0;
            end
            if (hit) begin
                ax = 0;
                if (ov[1] < ov[ax]) ax = 1;
                if (ov[2] < ov[ax]) ax = 2;
                hv = ov[ax] / 2;
                pos[ax] = (s[ax] < o[ax]) ? s[ax] - hv : s[ax] + hv;
                mv_f = 1'b1;
            end
        end else begin
            rad = it.other_radius;
            near = 1'b1;
            for (int i = 0; i < 3; i++) begin
                c = o[i];
                if (c > s[i] + hb[i]) c = s[i] + hb[i];
                if (c < s[i] - hb[i]) c = s[i] - hb[i];
                d[i] = c - o[i];
                if ((d[i] < 0 ? -d[i] : d[i]) >= rad) near = 1'b0;
            end
            if (near) begin
                sum = 0;
                r2 = longint'(rad) * longint'(rad);
                for (int i = 0; i < 3; i++) begin
                    m = d[i] < 0 ? -d[i] : d[i];
                    sum += m * m;
                end
                if (sum != 0 && sum < r2) begin
                    dlen = root_floor(sum);
                    if (sum - dlen * dlen > dlen) dlen += 1;
                    pen = rad - longint'(dlen);
                    if (pen > 0 && dlen != 0) begin
                        for (int i = 0; i < 3; i++) begin
                            m = d[i] < 0 ? -d[i] : d[i];
                            mv = longint'((m * longint'(pen) + dlen / 2) / dlen);
                            pos[i] = d[i] < 0 ? s[i] - mv : s[i] + mv;
                        end
                        mv_f = 1'b1;
                    end
                end
            end
        end
        q.new_x = clip32(pos[0]);
        q.new_y = clip32(pos[1]);
        q.new_z = clip32(pos[2]);
        q.moved = mv_f;
        return q;
    endfunction

    task automatic send_event(t_item it);
        while (!no_idle && $urandom_range(99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.kind;
        s_axis_tdata  <= {4'd0, it.other_radius, it.other_half_z, it.other_half_y,
                          it.other_half_x, it.other_z, it.other_y, it.other_x,
                          it.self_z, it.self_y, it.self_x};
        do @(posedge i_clk); while (!s_axis_tready);
        pos_q.push_back(push_out(it));
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_half(logic [1:0] idx, logic [30:0] val);
        s_axis_tvalid <= 1'b0;
        wait (pos_q.size() == 0);
        repeat (60) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        hext[idx] = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_halves(logic [30:0] hx, logic [30:0] hy, logic [30:0] hz);
        write_half(REG_HX, hx);
        write_half(REG_HY, hy);
        write_half(REG_HZ, hz);
    endtask

    function automatic t_item mk(bit k, longint sx, longint sy, longint sz,
                                 longint ox, longint oy, longint oz,
                                 longint hx, longint hy, longint hz, longint r);
        t_item it;
        it.kind = k;
        it.self_x = sx[31:0];  it.self_y = sy[31:0];  it.self_z = sz[31:0];
        it.other_x = ox[31:0]; it.other_y = oy[31:0]; it.other_z = oz[31:0];
        it.other_half_x = hx[30:0]; it.other_half_y = hy[30:0];
        it.other_half_z = hz[30:0]; it.other_radius = r[30:0];
        return it;
    endfunction

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2 * 65536 * 8)) - 65536 * 8);
            2: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(65536 * 4)
                                        : 32'h8000_0000 + $urandom_range(65536 * 4);
            default: return 32'($signed($urandom_range(2 * 2048)) - 2048);
        endcase
    endfunction

    function automatic logic [30:0] rnd_half();
        case ($urandom_range(3))
            0: return 31'($urandom);
            1: return 31'($urandom_range(65536 * 4));
            2: return 31'($urandom_range(16));
            default: return 31'(32'h7fff_ffff - $urandom_range(3));
        endcase
    endfunction

    task automatic test_box_directed();
        send_event(mk(0, 0, 0, 0, 0, 0, 0, 65536, 65536, 65536, 0));     // equal centres
        send_event(mk(0, 0, 0, 0, 32768, 32768, 32768, 65536, 65536, 65536, 5)); // tie
        send_event(mk(0, 0, 0, 0, 0, 16384, 16384, 65536, 65536, 65536, 0));  // y, z tie
        send_event(mk(0, 0, 0, 0, 131072, 0, 0, 65536, 65536, 65536, 0));  // touching
        send_event(mk(0, 0, 0, 0, 131071, 0, 0, 65536, 65536, 65536, 0));  // half is zero
        send_event(mk(0, 100, 0, 0, -100, 0, 0, 65536, 65536, 65536, 0));
        send_event(mk(0, 32'sh7fffffff, 0, 0, 32'sh7fffffff - 1000, 0, 0,
                      31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 0));
        send_event(mk(0, -2147483648, -2147483648, -2147483648, -2147483647, 0, 0,
                      31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff));
        send_event(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_sphere_directed();
        send_event(mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 65536));          // centre inside
        send_event(mk(1, 0, 0, 0, 100000, 0, 0, 0, 0, 0, 65536));     // near, x only
        send_event(mk(1, 0, 0, 0, -100000, -90000, 0, 0, 0, 0, 65536));
        send_event(mk(1, 0, 0, 0, 131072, 0, 0, 0, 0, 0, 65536));     // exactly touching
        send_event(mk(1, 0, 0, 0, 65538, 0, 0, 0, 0, 0, 2));          // distance equals radius
        send_event(mk(1, 0, 0, 0, 70000, 70000, 70000, 0, 0, 0, 0));  // zero radius
        send_event(mk(1, 0, 0, 0, 300000, 0, 0, 0, 0, 0, 65536));     // far
        send_event(mk(1, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                      -2147483648, -2147483648, -2147483648, 0, 0, 0, 31'h7fffffff));
        send_event(mk(1, 32'sh7fff0000, 0, 0, 32'sh7fffffff, 0, 0, 0, 0, 0, 31'h7fffffff));
    endtask

    task automatic test_random(int count);
        t_item it;
        int span;
        for (int n = 0; n < count; n++) begin
            no_idle = (n % 400) >= 320;
            it.kind = 1'($urandom_range(1));
            it.self_x = rnd_coord(); it.self_y = rnd_coord(); it.self_z = rnd_coord();
            it.other_half_x = rnd_half(); it.other_half_y = rnd_half();
            it.other_half_z = rnd_half(); it.other_radius = rnd_half();
            if ($urandom_range(99) < 75) begin
                // other object placed near this box so contact is likely
                span = $urandom_range(1) ? 65536 * 3 : 256;
                it.other_x = it.self_x + 32'($signed($urandom_range(2 * span)) - span);
                it.other_y = it.self_y + 32'($signed($urandom_range(2 * span)) - span);
                it.other_z = it.self_z + 32'($signed($urandom_range(2 * span)) - span);
                if ($urandom_range(1)) it.other_radius = 31'($urandom_range(65536 * 4));
            end else begin
                it.other_x = rnd_coord(); it.other_y = rnd_coord(); it.other_z = rnd_coord();
            end
            send_event(it);
        end
        no_idle = 1'b0;
    endtask

    always @(negedge i_clk)
        m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 34);

    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_recv++;
            if (pos_q.size() == 0) begin
                $error("unexpected word: %h moved %b", m_axis_tdata, m_axis_tuser);
                n_err++;
            end else begin
                e = pos_q.pop_front();
                n_moved += e.moved;
                if (m_axis_tdata[31:0] !== e.new_x) begin
                    $error("new_x exp %h got %h", e.new_x, m_axis_tdata[31:0]); n_err++;
                end
                if (m_axis_tdata[63:32] !== e.new_y) begin
                    $error("new_y exp %h got %h", e.new_y, m_axis_tdata[63:32]); n_err++;
                end
                if (m_axis_tdata[95:64] !== e.new_z) begin
                    $error("new_z exp %h got %h", e.new_z, m_axis_tdata[95:64]); n_err++;
                end
                if (m_axis_tuser !== e.moved) begin
                    $error("moved exp %b got %b", e.moved, m_axis_tuser); n_err++;
                end
            end
        end
    end

    initial begin
        hext[0] = HALF_RESET; hext[1] = HALF_RESET; hext[2] = HALF_RESET;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_box_directed();
        test_sphere_directed();
        test_random(400);
        set_halves(31'd0, 31'd0, 31'd0);
        test_box_directed();
        test_random(300);
        set_halves(31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
        test_sphere_directed();
        test_random(300);
        set_halves(31'd3, 31'd131072, 31'd40000);
        test_random(300);
        set_halves(31'($urandom), 31'($urandom_range(65536 * 4)),
                   31'($urandom_range(65536 * 4)));
        test_random(300);
        set_halves(HALF_RESET, HALF_RESET, HALF_RESET);
        test_random(300);
        s_axis_tvalid <= 1'b0;
        wait (pos_q.size() == 0);
        repeat (80) @(posedge i_clk);
        if (pos_q.size() != 0) n_err++;
        $display("covered %0d events (%0d pushed) over six half-extent settings, %0d words back",
                 n_sent, n_moved, n_recv);
        if (n_err == 0) begin
            $display("[box_collision_push_out] OK");
        end else begin
            $display("[box_collision_push_out] ERROR");
        end
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/bcpo_pkg.sv
rtl/bcpo_front.sv
rtl/bcpo_fifo.sv
rtl/bcpo_back.sv
rtl/box_collision_push_out.sv
bench/tb_box_collision_push_out.sv
